// File: src/dsi_pkg.sv
// dsi_pkg: shared constants, types and fixed point helpers for the
// density segment interpolator. No dependencies.
package dsi_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        word_t x;
        word_t y;
        logic  last;
    } point_t;

    typedef struct packed {
        word_t start;
        word_t value;
        word_t slope;
        logic  ovf;
        logic  last;
    } seg_t;

    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return s[WORD_BITS-1:0];
    endfunction
endpackage

// File: src/dsi_front.sv
// dsi_front: accepts points and queues them for the back end.
// Depends on dsi_pkg.
module dsi_front
    import dsi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   full,
    input  point_t pin,
    output logic   qv,
    input  logic   qtake,
    output point_t qout
);
    localparam int QD = 4;
    point_t q_reg [QD];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full = (cnt_reg == 3'(QD));
    assign qv   = (cnt_reg != 3'd0);
    assign qout = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            q_reg[wp_reg] <= pin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= wp_reg + 2'd1;
            if (qtake && qv)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push && !full) - 3'(qtake && qv);
        end
    end
endmodule

// File: src/dsi_mul.sv
// dsi_mul: multicycle signed fixed point multiplier, saturating.
// Depends on dsi_pkg.
module dsi_mul
    import dsi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t a,
    input  word_t b,
    output logic  done,
    output word_t p
);
    localparam int PW = 2*WORD_BITS;
    logic [WORD_BITS-1:0] ma_reg, mb_reg;
    logic neg_reg;
    logic [PW-1:0] prod_reg;
    logic [1:0] st_reg;
    logic [PW-1:0] sh;

    always_comb
    begin
        sh = prod_reg >> FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
            done   <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (st_reg)
                2'd0:
                begin
                    if (start)
                    begin
                        ma_reg  <= a[WORD_BITS-1] ? WORD_BITS'(-a) : a;
                        mb_reg  <= b[WORD_BITS-1] ? WORD_BITS'(-b) : b;
                        neg_reg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
                        st_reg  <= 2'd1;
                    end
                end
                2'd1:
                begin
                    prod_reg <= PW'(ma_reg) * PW'(mb_reg);
                    st_reg   <= 2'd2;
                end
                2'd2:
                begin
                    if (!neg_reg)
                        p <= (sh > PW'(WORD_MAX)) ? WORD_MAX : sh[WORD_BITS-1:0];
                    else
                        p <= (sh > PW'(WORD_MAX) + PW'(1)) ? WORD_MIN
                             : WORD_BITS'(-sh[WORD_BITS-1:0]);
                    done   <= 1'b1;
                    st_reg <= 2'd0;
                end
                default: st_reg <= 2'd0;
            endcase
        end
    end
endmodule

// File: src/dsi_div.sv
// dsi_div: radix-2 restoring divider computing (n << FRAC_BITS) / d,
// truncated and saturated, with overflow flag. Depends on dsi_pkg.
module dsi_div
    import dsi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t n,
    input  word_t d,
    output logic  done,
    output word_t q,
    output logic  ovf
);
    localparam int NW = WORD_BITS + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] num_reg, quo_reg;
    logic [WORD_BITS:0] rem_reg;
    logic [WORD_BITS-1:0] md_reg;
    logic neg_reg, busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [WORD_BITS:0] r2;
    logic [WORD_BITS-1:0] mn;

    assign r2 = {rem_reg[WORD_BITS-1:0], num_reg[NW-1]};
    assign mn = n[WORD_BITS-1] ? WORD_BITS'(-n) : n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                if (d == '0)
                begin
                    q    <= n[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
                    ovf  <= 1'b1;
                    done <= 1'b1;
                end
                else
                begin
                    num_reg  <= {mn, {FRAC_BITS{1'b0}}};
                    md_reg   <= d[WORD_BITS-1] ? WORD_BITS'(-d) : d;
                    neg_reg  <= n[WORD_BITS-1] ^ d[WORD_BITS-1];
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= CW'(NW);
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    num_reg <= num_reg << 1;
                    if (r2 >= {1'b0, md_reg})
                    begin
                        rem_reg <= r2 - {1'b0, md_reg};
                        quo_reg <= {quo_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= r2;
                        quo_reg <= {quo_reg[NW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CW'(1);
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                    if (!neg_reg)
                    begin
                        ovf <= quo_reg > NW'(WORD_MAX);
                        q   <= (quo_reg > NW'(WORD_MAX)) ? WORD_MAX
                               : quo_reg[WORD_BITS-1:0];
                    end
                    else
                    begin
                        ovf <= quo_reg > NW'(WORD_MAX) + NW'(1);
                        q   <= (quo_reg > NW'(WORD_MAX) + NW'(1)) ? WORD_MIN
                               : WORD_BITS'(-quo_reg[WORD_BITS-1:0]);
                    end
                end
            end
        end
    end
endmodule

// File: src/dsi_back.sv
// dsi_back: sequencer that forms slopes, knots and segments from queued
// points with a shared divider and multiplier. Depends on dsi_pkg,
// dsi_div, dsi_mul.
module dsi_back
    import dsi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   qv,
    output logic   qtake,
    input  point_t qin,
    output logic   ov,
    input  logic   otake,
    output seg_t   oseg
);
    localparam logic [4:0] S_IDLE = 5'd0, S_DISP = 5'd1, S_SLOPE = 5'd2,
        S_ITER = 5'd3, S_G1 = 5'd4, S_G2 = 5'd5, S_M1 = 5'd6, S_M2 = 5'd7,
        S_B = 5'd8, S_M3 = 5'd9, S_M4 = 5'd10, S_Z = 5'd11, S_SEG1 = 5'd12,
        S_SL1 = 5'd13, S_SEG2 = 5'd14, S_SL2 = 5'd15, S_POST = 5'd16,
        S_CLOSE = 5'd17, S_WAIT = 5'd18, S_ONE = 5'd19, S_TWO = 5'd20;

    logic [4:0] st_reg, ret_reg;
    point_t p_reg;
    logic [1:0] pc_reg;
    word_t xw_reg [3];
    word_t yp_reg, a_reg;
    word_t sw_reg [4];
    logic fin_reg, second_reg, iflag_reg, iter_reg;
    seg_t pend_reg;
    word_t ix0, ix1, ix2, iy1, iy2, iy3, iy4;
    word_t g1_reg, g2_reg, t1_reg, b_reg, z_reg;

    logic  d_start, m_start, d_done, m_done, d_ovf;
    word_t d_n, d_d, d_q, m_a, m_b, m_p;

    dsi_div u_div (.clk, .rst_n, .start(d_start), .n(d_n), .d(d_d),
                   .done(d_done), .q(d_q), .ovf(d_ovf));
    dsi_mul u_mul (.clk, .rst_n, .start(m_start), .a(m_a), .b(m_b),
                   .done(m_done), .p(m_p));

    logic issued_reg;

    always_comb
    begin
        if (!second_reg)
        begin
            ix0 = xw_reg[0]; ix1 = xw_reg[1]; ix2 = xw_reg[2];
            iy1 = sw_reg[0]; iy2 = sw_reg[1]; iy3 = sw_reg[2]; iy4 = sw_reg[3];
        end
        else
        begin
            ix0 = xw_reg[1]; ix1 = xw_reg[2]; ix2 = p_reg.x;
            iy1 = sw_reg[1]; iy2 = sw_reg[2]; iy3 = sw_reg[3]; iy4 = sw_reg[3];
        end
    end

    always_comb
    begin
        d_n = '0; d_d = '0; m_a = '0; m_b = '0;
        unique case (st_reg)
            S_SLOPE: begin d_n = sat_sub(p_reg.y, yp_reg); d_d = sat_sub(p_reg.x, xw_reg[2]); end
            S_TWO:   begin d_n = p_reg.y; d_d = p_reg.x; end
            S_G1:    begin d_n = sat_sub(iy2, iy1); d_d = sat_sub(ix1, ix0); end
            S_G2:    begin d_n = sat_sub(iy4, iy3); d_d = sat_sub(ix2, ix1); end
            S_M1:    begin m_a = iy3; m_b = g1_reg; end
            S_M2:    begin m_a = iy2; m_b = g2_reg; end
            S_B:     begin d_n = t1_reg; d_d = sat_add(g1_reg, g2_reg); end
            S_M3:    begin m_a = sat_sub(iy2, a_reg); m_b = ix0; end
            S_M4:    begin m_a = sat_sub(b_reg, iy2); m_b = ix1; end
            S_Z:     begin d_n = t1_reg; d_d = sat_sub(b_reg, a_reg); end
            S_SL1:   begin d_n = sat_sub(iy2, a_reg); d_d = sat_sub(z_reg, ix0); end
            S_SL2:   begin d_n = sat_sub(b_reg, iy2); d_d = sat_sub(ix1, z_reg); end
            default: ;
        endcase
    end

    assign d_start = !issued_reg && (st_reg == S_SLOPE || st_reg == S_TWO ||
        st_reg == S_G1 || st_reg == S_G2 || st_reg == S_B || st_reg == S_Z ||
        st_reg == S_SL1 || st_reg == S_SL2);
    assign m_start = !issued_reg && (st_reg == S_M1 || st_reg == S_M2 ||
        (st_reg == S_M3 && $signed(b_reg) > $signed(a_reg)) || st_reg == S_M4);
    assign qtake = (st_reg == S_IDLE) && qv;

    always_ff @(posedge clk)
    begin
        if (qtake)
            p_reg <= qin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ret_reg <= S_IDLE; issued_reg <= 1'b0;
            pc_reg <= '0; yp_reg <= '0; a_reg <= '0; ov <= 1'b0;
            fin_reg <= 1'b0; second_reg <= 1'b0; iflag_reg <= 1'b0;
            iter_reg <= 1'b0;
            for (int i = 0; i < 3; i++) xw_reg[i] <= '0;
            for (int i = 0; i < 4; i++) sw_reg[i] <= '0;
        end
        else
        begin
            if (otake && ov)
                ov <= 1'b0;
            if (d_start || m_start)
                issued_reg <= 1'b1;
            if (d_done || m_done)
                issued_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (qv) st_reg <= S_DISP;
                S_DISP:
                begin
                    second_reg <= 1'b0;
                    if (pc_reg == 2'd0 && p_reg.last)
                    begin
                        pend_reg <= '{p_reg.x, p_reg.y, '0, 1'b0, 1'b1};
                        ret_reg <= S_POST; fin_reg <= 1'b1; st_reg <= S_WAIT;
                    end
                    else if (pc_reg == 2'd0)
                        st_reg <= S_POST;
                    else if (pc_reg == 2'd1 && p_reg.last)
                        st_reg <= S_TWO;
                    else
                        st_reg <= S_SLOPE;
                end
                S_TWO:
                    if (d_done)
                    begin
                        pend_reg <= '{xw_reg[2], d_q, '0, d_ovf, 1'b1};
                        ret_reg <= S_POST; fin_reg <= 1'b1; st_reg <= S_WAIT;
                    end
                S_SLOPE:
                    if (d_done)
                    begin
                        sw_reg[0] <= sw_reg[1]; sw_reg[1] <= sw_reg[2];
                        sw_reg[2] <= sw_reg[3]; sw_reg[3] <= d_q;
                        st_reg <= S_ITER;
                    end
                S_ITER:
                begin
                    if (!second_reg && !iter_reg && pc_reg == 2'd3)
                    begin
                        iter_reg <= 1'b1; st_reg <= S_G1;
                    end
                    else if (p_reg.last && !fin_reg)
                    begin
                        second_reg <= 1'b1; fin_reg <= 1'b1; st_reg <= S_G1;
                    end
                    else if (p_reg.last)
                    begin
                        pend_reg <= '{xw_reg[2], sw_reg[3], '0, 1'b0, 1'b1};
                        ret_reg <= S_POST; st_reg <= S_WAIT;
                    end
                    else
                        st_reg <= S_POST;
                end
                S_G1: if (d_done) begin g1_reg <= d_q; iflag_reg <= d_ovf; st_reg <= S_G2; end
                S_G2: if (d_done) begin g2_reg <= d_q; iflag_reg <= iflag_reg | d_ovf; st_reg <= S_M1; end
                S_M1: if (m_done) begin t1_reg <= m_p; st_reg <= S_M2; end
                S_M2:
                    if (m_done)
                    begin
                        t1_reg <= sat_add(t1_reg, m_p);
                        if (sat_add(g1_reg, g2_reg) == '0)
                        begin
                            b_reg <= '0; st_reg <= S_M3;
                        end
                        else
                            st_reg <= S_B;
                    end
                S_B: if (d_done) begin b_reg <= d_q; iflag_reg <= iflag_reg | d_ovf; st_reg <= S_M3; end
                S_M3:
                    if ($signed(b_reg) <= $signed(a_reg))
                    begin
                        z_reg <= ix1; st_reg <= S_SEG1;
                    end
                    else if (m_done)
                    begin
                        t1_reg <= m_p; st_reg <= S_M4;
                    end
                S_M4: if (m_done) begin t1_reg <= sat_add(t1_reg, m_p); st_reg <= S_Z; end
                S_Z: if (d_done) begin z_reg <= d_q; iflag_reg <= iflag_reg | d_ovf; st_reg <= S_SEG1; end
                S_SEG1: st_reg <= ($signed(z_reg) > $signed(ix0)) ? S_SL1 : S_SEG2;
                S_SL1:
                    if (d_done)
                    begin
                        pend_reg <= '{ix0, a_reg, d_q, iflag_reg | d_ovf, 1'b0};
                        ret_reg <= S_SEG2; st_reg <= S_WAIT;
                    end
                S_SEG2:
                begin
                    if ($signed(z_reg) < $signed(ix1))
                        st_reg <= S_SL2;
                    else
                    begin
                        a_reg <= b_reg; st_reg <= S_ITER;
                    end
                end
                S_SL2:
                    if (d_done)
                    begin
                        pend_reg <= '{z_reg, iy2, d_q, iflag_reg | d_ovf, 1'b0};
                        a_reg <= b_reg; ret_reg <= S_ITER; st_reg <= S_WAIT;
                    end
                S_WAIT:
                    if (!ov)
                    begin
                        oseg <= pend_reg; ov <= 1'b1; st_reg <= ret_reg;
                    end
                S_POST:
                begin
                    if (p_reg.last)
                    begin
                        pc_reg <= '0; yp_reg <= '0; a_reg <= '0;
                        for (int i = 0; i < 3; i++) xw_reg[i] <= '0;
                        for (int i = 0; i < 4; i++) sw_reg[i] <= '0;
                    end
                    else
                    begin
                        xw_reg[0] <= xw_reg[1]; xw_reg[1] <= xw_reg[2];
                        xw_reg[2] <= p_reg.x; yp_reg <= p_reg.y;
                        if (pc_reg != 2'd3) pc_reg <= pc_reg + 2'd1;
                    end
                    fin_reg <= 1'b0; second_reg <= 1'b0; iter_reg <= 1'b0;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/density_segment_interpolator.sv
// density_segment_interpolator: top level, point queue front end and
// segment sequencer back end. Depends on dsi_pkg, dsi_front, dsi_back.
//
//  channel  | handshake    | fields
//  points   | push / full  | x_pos, y_val, last_point
//  segments | pop / empty  | seg_start, seg_value, seg_slope, seg_overflow,
//           |              | last_segment
//
// A point costs one slope division plus up to two iterations of six
// divisions and four multiplies. Divisions use the shared radix-2 divider
// and multiplies the shared multiplier. A four-entry point queue lets input
// proceed while the back end works; one output register holds a segment
// until popped and stalls the sequencer. Reset clears the control state,
// not the data registers such as the queue entries and the output segment.
module density_segment_interpolator
    import dsi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  word_t x_pos,
    input  word_t y_val,
    input  logic  last_point,
    output logic  empty,
    input  logic  pop,
    output word_t seg_start,
    output word_t seg_value,
    output word_t seg_slope,
    output logic  seg_overflow,
    output logic  last_segment
);
    logic   qv, qtake, ov;
    point_t qp;
    seg_t   sg;

    dsi_front u_front (.clk, .rst_n, .push, .full,
                       .pin('{x_pos, y_val, last_point}),
                       .qv, .qtake, .qout(qp));
    dsi_back u_back (.clk, .rst_n, .qv, .qtake, .qin(qp),
                     .ov, .otake(pop), .oseg(sg));

    assign empty        = !ov;
    assign seg_start    = sg.start;
    assign seg_value    = sg.value;
    assign seg_slope    = sg.slope;
    assign seg_overflow = sg.ovf;
    assign last_segment = sg.last;
endmodule
